// ===== hdl/bfb_pkg.sv =====
// Shared constants and helpers for the beacon frame builder.
// Holds the frame layout offsets, fixed field bytes and the rate tables.
// No dependencies.
`default_nettype none

package bfb_pkg;

   // Widths of the stream payloads, padded to whole bytes.
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 80;

   // SSID store geometry.
   localparam int unsigned MAX_SSID_BYTES = 32;
   localparam int unsigned SSID_ADDR_W    = $clog2(MAX_SSID_BYTES);
   localparam int unsigned SSID_CNT_W     = SSID_ADDR_W + 1;

   // Frame byte positions.
   localparam logic [6:0] POS_FC0       = 7'd0;
   localparam logic [6:0] POS_DA_FIRST  = 7'd4;
   localparam logic [6:0] POS_SA_FIRST  = 7'd10;
   localparam logic [6:0] POS_BSSID_END = 7'd21;
   localparam logic [6:0] POS_INTERVAL  = 7'd32;
   localparam logic [6:0] POS_CAP_LO    = 7'd34;
   localparam logic [6:0] POS_CAP_HI    = 7'd35;
   localparam logic [6:0] POS_SSID_LEN  = 7'd37;
   localparam logic [6:0] POS_SSID_DATA = 7'd38;
   localparam logic [6:0] FIXED_LENGTH  = 7'd51;

   // Offsets inside the tail that follows the SSID bytes.
   localparam logic [6:0] TAIL_RATES_ID  = 7'd0;
   localparam logic [6:0] TAIL_RATES_LEN = 7'd1;
   localparam logic [6:0] TAIL_RATE_LAST = 7'd9;
   localparam logic [6:0] TAIL_DS_ID     = 7'd10;
   localparam logic [6:0] TAIL_DS_LEN    = 7'd11;
   localparam logic [6:0] TAIL_CHANNEL   = 7'd12;

   // Fixed byte values.
   localparam logic [7:0] BYTE_BEACON_FC = 8'h80;
   localparam logic [7:0] BYTE_BROADCAST = 8'hFF;
   localparam logic [7:0] BYTE_INTERVAL  = 8'h64;
   localparam logic [7:0] BYTE_CAP_LO    = 8'h01;
   localparam logic [7:0] BYTE_CAP_HI    = 8'h04;
   localparam logic [7:0] BYTE_RATES_ID  = 8'h01;
   localparam logic [7:0] BYTE_RATES_LEN = 8'h08;
   localparam logic [7:0] BYTE_DS_ID     = 8'h03;
   localparam logic [7:0] BYTE_DS_LEN    = 8'h01;

   // Supported rates, eight entries per band.
   function automatic logic [7:0] rate_byte(input logic band_5g, input logic [2:0] idx);
      logic [7:0] r;
      if (band_5g) begin
         case (idx)
            3'd0:    r = 8'h8C;
            3'd1:    r = 8'h12;
            3'd2:    r = 8'h98;
            3'd3:    r = 8'h24;
            3'd4:    r = 8'hB0;
            3'd5:    r = 8'h48;
            3'd6:    r = 8'h60;
            default: r = 8'h6C;
         endcase
      end else begin
         case (idx)
            3'd0:    r = 8'h82;
            3'd1:    r = 8'h84;
            3'd2:    r = 8'h8B;
            3'd3:    r = 8'h96;
            3'd4:    r = 8'h24;
            3'd5:    r = 8'h30;
            3'd6:    r = 8'h48;
            default: r = 8'h6C;
         endcase
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/beacon_frame_builder.sv =====
// Beacon frame builder top level: SSID store, byte-serial frame generator and word output.
// Depends on bfb_pkg for layout constants and the rate tables.
`default_nettype none

// Channel   Direction  Beat contents
// req_*     in         one SSID byte (optional), end mark, address, channel, band
// rsp_*     out        one frame word of up to eight bytes, end mark, length
//
// An item without an end mark adds its SSID byte, if it has one, to the store. The end
// item starts the frame, which is generated one byte per cycle into a 64-bit shift
// register, pausing at each word boundary: each word takes eight byte fetches, then the
// last byte lands and the word is handed over, and a frame is ceil(length/8) words.
// The SSID memory is read one byte a cycle with a registered read port, which sets the
// byte pipeline. Reset is synchronous and clears the control state only; the SSID memory
// is never cleared, as only entries written for the current SSID are read. A stalled
// result channel holds the finished word and halts the byte generator, and no input is
// accepted until the whole frame has been handed to the output register.

module beacon_frame_builder
   import bfb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // ssid_byte[7:0], station_addr[55:8], channel_num[63:56], band_5g[64], zero pad
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // has_byte[0]
   input  wire logic                  req_tuser,
   input  wire logic                  req_tlast,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // frame_word[63:0], valid_bytes[67:64], frame_length[74:68], zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // Input fields.
   logic [7:0]  in_ssid_byte;
   logic [47:0] in_station_addr;
   logic [7:0]  in_channel_num;
   logic        in_band_5g;
   logic        req_take;

   assign in_ssid_byte    = req_tdata[7:0];
   assign in_station_addr = req_tdata[55:8];
   assign in_channel_num  = req_tdata[63:56];
   assign in_band_5g      = req_tdata[64];

   logic state_ff, state_in;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;

   // Byte fetch stage: the position counter runs over the frame rounded up to whole words,
   // so that the tail of the last word is filled with zero bytes.
   logic [6:0] pos_ff, pos_in;
   logic       fetch_done_ff, fetch_done_in;
   logic       fetch;
   logic       fetch_last;

   // SSID store and fill count.
   logic [7:0]            ssid_mem [MAX_SSID_BYTES];
   logic [SSID_CNT_W-1:0] ssid_count_ff, ssid_count_in;
   logic                  store_we;
   logic [SSID_CNT_W-1:0] count_after;
   logic [7:0]            rd_data_ff;
   logic [6:0]            rd_pos;

   assign store_we    = req_take && req_tuser && (ssid_count_ff < SSID_CNT_W'(MAX_SSID_BYTES));
   assign count_after = store_we ? ssid_count_ff + SSID_CNT_W'(1) : ssid_count_ff;

   always_comb begin
      ssid_count_in = ssid_count_ff;
      if (req_take) begin
         ssid_count_in = req_tlast ? '0 : count_after;
      end
   end

   // The memory is addressed by the offset of the byte being fetched within the SSID.
   assign rd_pos = pos_ff - POS_SSID_DATA;

   always_ff @(posedge clock) begin
      if (store_we) begin
         ssid_mem[ssid_count_ff[SSID_ADDR_W-1:0]] <= in_ssid_byte;
      end
      rd_data_ff <= ssid_mem[rd_pos[SSID_ADDR_W-1:0]];
   end

   // Frame parameters captured from the end item.
   logic [SSID_CNT_W-1:0] len_ff, len_in;
   logic [6:0]            frame_len_ff, frame_len_in;
   logic [47:0]           addr_ff, addr_in;
   logic [7:0]            chan_ff, chan_in;
   logic                  band_ff, band_in;

   // Byte stage: the fetched position, registered in the same cycle as the memory read, meets its read data.
   logic [6:0] pos1_ff, pos1_in;
   logic       v1_ff, v1_in;
   logic       v1_completes;

   // Word assembly.
   logic [63:0] word_ff, word_in;
   logic        wdone_ff, wdone_in;

   // Output register.
   logic [63:0] out_word_ff, out_word_in;
   logic [3:0]  out_valid_ff, out_valid_in;
   logic        out_end_ff, out_end_in;
   logic [6:0]  out_len_ff, out_len_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        load_out;

   assign v1_completes = v1_ff && (pos1_ff[2:0] == 3'd7);
   assign fetch        = (state_ff == ST_RUN) && !fetch_done_ff && !wdone_ff && !v1_completes;
   assign fetch_last   = (pos_ff[2:0] == 3'd7) && ((pos_ff + 7'd1) >= frame_len_ff);
   assign load_out     = wdone_ff && (!rsp_valid_ff || rsp_tready);

   // Frame byte for the position held in the byte stage.
   logic [6:0] ssid_end;
   logic [6:0] tail_rel;
   logic [6:0] rate_rel;
   logic [7:0] frame_byte;

   assign ssid_end = POS_SSID_DATA + 7'(len_ff);
   assign tail_rel = pos1_ff - ssid_end;
   assign rate_rel = tail_rel - 7'd2;

   always_comb begin
      frame_byte = 8'h00;
      if (pos1_ff == POS_FC0) begin
         frame_byte = BYTE_BEACON_FC;
      end else if (pos1_ff >= POS_DA_FIRST && pos1_ff < POS_SA_FIRST) begin
         frame_byte = BYTE_BROADCAST;
      end else if (pos1_ff >= POS_SA_FIRST && pos1_ff <= POS_BSSID_END) begin
         frame_byte = addr_ff[47:40];
      end else if (pos1_ff == POS_INTERVAL) begin
         frame_byte = BYTE_INTERVAL;
      end else if (pos1_ff == POS_CAP_LO) begin
         frame_byte = BYTE_CAP_LO;
      end else if (pos1_ff == POS_CAP_HI) begin
         frame_byte = BYTE_CAP_HI;
      end else if (pos1_ff == POS_SSID_LEN) begin
         frame_byte = 8'(len_ff);
      end else if (pos1_ff >= POS_SSID_DATA && pos1_ff < ssid_end) begin
         frame_byte = rd_data_ff;
      end else if (pos1_ff >= ssid_end) begin
         if (tail_rel == TAIL_RATES_ID) begin
            frame_byte = BYTE_RATES_ID;
         end else if (tail_rel == TAIL_RATES_LEN) begin
            frame_byte = BYTE_RATES_LEN;
         end else if (tail_rel <= TAIL_RATE_LAST) begin
            frame_byte = rate_byte(band_ff, rate_rel[2:0]);
         end else if (tail_rel == TAIL_DS_ID) begin
            frame_byte = BYTE_DS_ID;
         end else if (tail_rel == TAIL_DS_LEN) begin
            frame_byte = BYTE_DS_LEN;
         end else if (tail_rel == TAIL_CHANNEL) begin
            frame_byte = chan_ff;
         end
      end
   end

   // Output word bookkeeping from the completing position.
   logic       word_is_last;
   logic [6:0] bytes_left;

   assign word_is_last = (pos1_ff + 7'd1) >= frame_len_ff;
   assign bytes_left   = frame_len_ff - {pos1_ff[6:3], 3'b000};

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      frame_len_in  = frame_len_ff;
      addr_in       = addr_ff;
      chan_in       = chan_ff;
      band_in       = band_ff;
      pos_in        = pos_ff;
      fetch_done_in = fetch_done_ff;
      pos1_in       = pos1_ff;
      v1_in         = fetch;
      word_in       = word_ff;
      wdone_in      = wdone_ff;
      out_word_in   = out_word_ff;
      out_valid_in  = out_valid_ff;
      out_end_in    = out_end_ff;
      out_len_in    = out_len_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_tlast) begin
               state_in      = ST_RUN;
               len_in        = count_after;
               frame_len_in  = FIXED_LENGTH + 7'(count_after);
               addr_in       = in_station_addr;
               chan_in       = in_channel_num;
               band_in       = in_band_5g;
               pos_in        = '0;
               fetch_done_in = 1'b0;
            end
         end
         ST_RUN: begin
            if (fetch) begin
               pos1_in = pos_ff;
               pos_in  = pos_ff + 7'd1;
               if (fetch_last) begin
                  fetch_done_in = 1'b1;
               end
            end
            if (v1_ff) begin
               word_in = {word_ff[55:0], frame_byte};
               // The address register rotates a byte per use, so it is whole again
               // after each of its two copies.
               if (pos1_ff >= POS_SA_FIRST && pos1_ff <= POS_BSSID_END) begin
                  addr_in = {addr_ff[39:0], addr_ff[47:40]};
               end
               if (pos1_ff[2:0] == 3'd7) begin
                  wdone_in = 1'b1;
               end
            end
            if (load_out) begin
               wdone_in     = 1'b0;
               rsp_valid_in = 1'b1;
               out_word_in  = word_ff;
               out_end_in   = word_is_last;
               out_valid_in = word_is_last ? bytes_left[3:0] : 4'd8;
               out_len_in   = frame_len_ff;
            end
            if (fetch_done_ff && !v1_ff && !wdone_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ssid_count_ff <= '0;
         fetch_done_ff <= 1'b1;
         v1_ff         <= 1'b0;
         wdone_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ssid_count_ff <= ssid_count_in;
         fetch_done_ff <= fetch_done_in;
         v1_ff         <= v1_in;
         wdone_ff      <= wdone_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      frame_len_ff <= frame_len_in;
      addr_ff      <= addr_in;
      chan_ff      <= chan_in;
      band_ff      <= band_in;
      pos_ff       <= pos_in;
      pos1_ff      <= pos1_in;
      word_ff      <= word_in;
      out_word_ff  <= out_word_in;
      out_valid_ff <= out_valid_in;
      out_end_ff   <= out_end_in;
      out_len_ff   <= out_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_end_ff;
   assign rsp_tdata  = {5'b00000, out_len_ff, out_valid_ff, out_word_ff};

endmodule

`default_nettype wire
